### rtl/core/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg
// Shared widths, codes and types of the Chebyshev series evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package cse_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int COEF_DEPTH = 32;

    localparam int IDX_W     = $clog2(COEF_DEPTH);
    localparam int CNT_W     = 6;
    localparam int CIDX_W    = 5;
    localparam int CFG_IDX_W = 2;
    // numerator 2x - low - high needs two guard bits
    localparam int NUM_W     = DATA_WIDTH + 2;

    typedef logic signed [DATA_WIDTH-1:0] t_data;

    localparam t_data VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam t_data VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef logic [1:0] t_alu_op;
    localparam t_alu_op ALU_MUL = 2'd0;
    localparam t_alu_op ALU_RND = 2'd1;
    localparam t_alu_op ALU_SUB = 2'd2;
    localparam t_alu_op ALU_ADD = 2'd3;

    typedef struct packed {
        t_alu_op op;
        logic    dbl;
    } t_alu_ctrl;

    typedef struct packed {
        logic done;
        logic sat;
    } t_div_stat;

    typedef logic [1:0] t_status;
    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_SAT   = 2'd1;
    localparam t_status STATUS_DEGEN = 2'd2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_COEF_COUNT = 2'd0;
    localparam t_cfg_idx CFG_RANGE_LOW  = 2'd1;
    localparam t_cfg_idx CFG_RANGE_HIGH = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam logic [CNT_W-1:0] COEF_COUNT_RST = 6'd1;
    localparam t_data            RANGE_LOW_RST  = -32'sd65536;
    localparam t_data            RANGE_HIGH_RST = 32'sd65536;

endpackage

`default_nettype wire

### rtl/core/cse_ram.sv
// ----------------------------------------------------------------------------
// cse_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/core/cse_div.sv
// ----------------------------------------------------------------------------
// cse_div
// Bit-serial restoring divider that maps x onto [-1,1]: y = num / den in
// fixed point, rounded half away from zero, saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [cse_pkg::NUM_W-1:0]     i_num,
    input  logic signed [cse_pkg::DATA_WIDTH:0]  i_den,
    output cse_pkg::t_data                       o_y,
    output cse_pkg::t_div_stat                   o_stat
);

    import cse_pkg::*;

    localparam int QB = DATA_WIDTH - 1;
    localparam int SH = QB - FRAC_BITS;
    localparam int CW = $clog2(QB);

    localparam logic [2:0] D_IDLE = 3'd0;
    localparam logic [2:0] D_ABS  = 3'd1;
    localparam logic [2:0] D_OVF  = 3'd2;
    localparam logic [2:0] D_ITER = 3'd3;
    localparam logic [2:0] D_RND  = 3'd4;

    logic [2:0]                r_state;
    logic signed [NUM_W-1:0]   r_num;
    logic signed [DATA_WIDTH:0] r_den;
    logic [NUM_W-1:0]          r_un;
    logic [DATA_WIDTH-1:0]     r_ud;
    logic                      r_neg;
    logic                      r_ovf;
    logic [DATA_WIDTH-1:0]     r_rem;
    logic [QB-1:0]             r_feed;
    logic [QB-1:0]             r_q;
    logic [CW-1:0]             r_cnt;

    logic                      w_ovf;
    logic [DATA_WIDTH:0]       w_trial;
    logic                      w_ge;
    logic                      w_rbit;
    logic [DATA_WIDTH-1:0]     w_qr;
    logic [DATA_WIDTH-1:0]     w_lim;
    logic                      w_sat;

    // integer part of the quotient beyond the format
    assign w_ovf   = (r_un >> SH) >= {{(NUM_W-DATA_WIDTH){1'b0}}, r_ud};
    assign w_trial = {r_rem, r_feed[QB-1]};
    assign w_ge    = w_trial >= {1'b0, r_ud};

    // round up when the remainder is at least half the divisor
    assign w_rbit  = {r_rem, 1'b0} >= {1'b0, r_ud};
    assign w_qr    = {1'b0, r_q} + DATA_WIDTH'(w_rbit);
    assign w_lim   = r_neg ? {1'b1, {QB{1'b0}}} : {1'b0, {QB{1'b1}}};
    assign w_sat   = r_ovf | (w_qr > w_lim);

    always_comb begin
        if (w_sat) begin
            o_y = r_neg ? VMIN : VMAX;
        end else if (r_neg) begin
            o_y = -$signed(w_qr);
        end else begin
            o_y = $signed(w_qr);
        end
    end

    assign o_stat.done = (r_state == D_RND);
    assign o_stat.sat  = w_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_state <= D_ABS;
                    end
                end
                D_ABS: begin
                    r_state <= D_OVF;
                end
                D_OVF: begin
                    r_state <= w_ovf ? D_RND : D_ITER;
                end
                D_ITER: begin
                    if (r_cnt == '0) begin
                        r_state <= D_RND;
                    end
                end
                D_RND: begin
                    r_state <= D_IDLE;
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == D_IDLE && i_start) begin
            r_num <= i_num;
            r_den <= i_den;
        end
        if (r_state == D_ABS) begin
            r_un  <= r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);
            r_ud  <= r_den[DATA_WIDTH] ? DATA_WIDTH'(-r_den) : DATA_WIDTH'(r_den);
            r_neg <= r_num[NUM_W-1] ^ r_den[DATA_WIDTH];
        end
        if (r_state == D_OVF) begin
            r_ovf  <= w_ovf;
            r_rem  <= DATA_WIDTH'(r_un >> SH);
            r_feed <= {r_un[SH-1:0], {FRAC_BITS{1'b0}}};
            r_cnt  <= CW'(QB - 1);
        end
        if (r_state == D_ITER) begin
            r_rem  <= w_ge ? DATA_WIDTH'(w_trial - {1'b0, r_ud}) : DATA_WIDTH'(w_trial);
            r_q    <= {r_q[QB-2:0], w_ge};
            r_feed <= r_feed << 1;
            r_cnt  <= r_cnt - 1'b1;
        end
    end

endmodule

`default_nettype wire

### rtl/core/cse_alu.sv
// ----------------------------------------------------------------------------
// cse_alu
// Shared arithmetic unit of the recurrence: multiply, round and double,
// saturating subtract and saturating add.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_alu (
    input  logic               i_clk,
    input  cse_pkg::t_alu_ctrl i_ctrl,
    input  cse_pkg::t_data     i_a,
    input  cse_pkg::t_data     i_b,
    output cse_pkg::t_data     o_res,
    output logic               o_sat
);

    import cse_pkg::*;

    localparam int PW = 2 * DATA_WIDTH;
    localparam int QW = PW - FRAC_BITS;

    logic [DATA_WIDTH-1:0] w_ua;
    logic [DATA_WIDTH-1:0] w_ub;
    logic [PW-1:0]         r_prod;
    logic                  r_pneg;

    logic [PW-1:0]         w_rsum;
    logic [QW-1:0]         w_q;
    logic [QW-1:0]         w_lim;
    logic                  w_rsat;
    t_data                 w_rv;
    logic                  w_dsat;
    t_data                 w_dv;

    logic                  w_sub;
    logic [DATA_WIDTH:0]   w_a_ext;
    logic [DATA_WIDTH:0]   w_b_ext;
    logic [DATA_WIDTH:0]   w_sum;
    logic                  w_asat;
    t_data                 w_av;

    assign w_ua = i_a[DATA_WIDTH-1] ? DATA_WIDTH'(-i_a) : DATA_WIDTH'(i_a);
    assign w_ub = i_b[DATA_WIDTH-1] ? DATA_WIDTH'(-i_b) : DATA_WIDTH'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.op == ALU_MUL) begin
            r_prod <= w_ua * w_ub;
            r_pneg <= i_a[DATA_WIDTH-1] ^ i_b[DATA_WIDTH-1];
        end
    end

    // round the magnitude, then apply the sign with saturation
    assign w_rsum = r_prod + PW'(1 << (FRAC_BITS - 1));
    assign w_q    = w_rsum[PW-1:FRAC_BITS];
    assign w_lim  = {{(QW-DATA_WIDTH){1'b0}}, VMAX} + QW'(r_pneg);
    assign w_rsat = w_q > w_lim;

    always_comb begin
        if (w_rsat) begin
            w_rv = r_pneg ? VMIN : VMAX;
        end else if (r_pneg) begin
            w_rv = -$signed(w_q[DATA_WIDTH-1:0]);
        end else begin
            w_rv = $signed(w_q[DATA_WIDTH-1:0]);
        end
    end

    assign w_dsat = i_ctrl.dbl & (w_rv[DATA_WIDTH-1] != w_rv[DATA_WIDTH-2]);

    always_comb begin
        if (w_dsat) begin
            w_dv = w_rv[DATA_WIDTH-1] ? VMIN : VMAX;
        end else if (i_ctrl.dbl) begin
            w_dv = w_rv <<< 1;
        end else begin
            w_dv = w_rv;
        end
    end

    // one adder serves both subtract and add
    assign w_sub   = (i_ctrl.op == ALU_SUB);
    assign w_a_ext = {i_a[DATA_WIDTH-1], i_a};
    assign w_b_ext = {i_b[DATA_WIDTH-1], i_b};
    assign w_sum   = w_a_ext + (w_sub ? ~w_b_ext : w_b_ext) + (DATA_WIDTH+1)'(w_sub);
    assign w_asat  = w_sum[DATA_WIDTH] != w_sum[DATA_WIDTH-1];

    always_comb begin
        if (w_asat) begin
            w_av = w_sum[DATA_WIDTH] ? VMIN : VMAX;
        end else begin
            w_av = $signed(w_sum[DATA_WIDTH-1:0]);
        end
    end

    always_comb begin
        unique case (i_ctrl.op)
            ALU_MUL: begin
                o_res = '0;
                o_sat = 1'b0;
            end
            ALU_RND: begin
                o_res = w_dv;
                o_sat = w_rsat | w_dsat;
            end
            ALU_SUB, ALU_ADD: begin
                o_res = w_av;
                o_sat = w_asat;
            end
            default: begin
                o_res = '0;
                o_sat = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/chebyshev_series_eval_core.sv
// ----------------------------------------------------------------------------
// chebyshev_series_eval_core
// Chebyshev series evaluator (Clenshaw recurrence), signed Q16.16.
// Input channel (i_valid / o_stall): operation 0 stores coef_value in slot
// coef_index and gives no result; operation 1 evaluates the series at x_value.
// Output channel (o_valid / i_stall): series_value and status per evaluation.
// Config port: coef_count, range_low, range_high; write only while idle.
// A coefficient write leaves the block free; the next transaction may follow at once.
// An evaluation raises o_valid once the divider and the recurrence over its
// N effective coefficients are done (the divider skips its iterations on
// overflow; a degenerate range skips both); o_stall stays high meanwhile
// and drops in the cycle o_valid rises. The bit-serial divider has
// 31 steps; per coefficient the shared unit runs multiply, round, subtract, add.
// The result sits in an output register; while the receiver stalls, a
// finished evaluation waits in its last step until the register is free.
// Reset clears the handshakes and loads the register defaults; the
// coefficient table has no reset and must be written before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module chebyshev_series_eval_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [cse_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cse_pkg::DATA_WIDTH-1:0]     i_cfg_wdata,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_operation,
    input  logic [cse_pkg::CIDX_W-1:0]         i_coef_index,
    input  logic signed [cse_pkg::DATA_WIDTH-1:0] i_coef_value,
    input  logic signed [cse_pkg::DATA_WIDTH-1:0] i_x_value,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [cse_pkg::DATA_WIDTH-1:0] o_series_value,
    output logic [1:0]                         o_status
);

    import cse_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_RND   = 3'd4;
    localparam logic [2:0] S_SUB   = 3'd5;
    localparam logic [2:0] S_ADD   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [CNT_W-1:0] r_coef_count;
    t_data            r_range_low;
    t_data            r_range_high;
    t_data            r_x;
    t_data            r_y;
    t_data            r_b1;
    t_data            r_b2;
    t_data            r_t;
    logic [IDX_W-1:0] r_idx;
    logic             r_sat;
    logic             r_degen;
    t_data            r_out_value;
    t_status          r_out_status;
    logic             r_out_valid;

    logic                     w_in_acc;
    logic                     w_eval_acc;
    logic                     w_fin_load;
    logic [IDX_W-1:0]         w_last_idx;
    logic signed [NUM_W-1:0]  w_num;
    logic signed [DATA_WIDTH:0] w_den;
    t_data                    w_y;
    t_div_stat                w_div_stat;
    t_alu_ctrl                w_alu_ctrl;
    t_data                    w_alu_a;
    t_data                    w_alu_b;
    t_data                    w_alu_res;
    logic                     w_alu_sat;
    logic [DATA_WIDTH-1:0]    w_coef_rd;
    logic                     w_coef_we;

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_series_value = r_out_value;
    assign o_status       = r_out_status;

    assign w_in_acc   = i_valid & ~o_stall;
    assign w_eval_acc = w_in_acc & (i_operation == OP_EVAL);
    assign w_fin_load = (r_state == S_FIN) & (~r_out_valid | ~i_stall);
    assign w_coef_we  = w_in_acc & (i_operation == OP_WRITE) &
                        (int'(i_coef_index) < COEF_DEPTH);

    // a count of zero acts as one, a count past the table as the full table
    always_comb begin
        if (r_coef_count == '0) begin
            w_last_idx = '0;
        end else if (int'(r_coef_count) > COEF_DEPTH) begin
            w_last_idx = IDX_W'(COEF_DEPTH - 1);
        end else begin
            w_last_idx = IDX_W'(r_coef_count - 1'b1);
        end
    end

    assign w_num = (NUM_W'(r_x) <<< 1) - NUM_W'(r_range_low) - NUM_W'(r_range_high);
    assign w_den = (DATA_WIDTH+1)'(r_range_high) - (DATA_WIDTH+1)'(r_range_low);

    cse_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (IDX_W'(i_coef_index)),
        .i_wdata (i_coef_value),
        .i_raddr (r_idx),
        .o_rdata (w_coef_rd)
    );

    cse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_START),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_y     (w_y),
        .o_stat  (w_div_stat)
    );

    always_comb begin
        w_alu_ctrl.op  = ALU_ADD;
        w_alu_ctrl.dbl = 1'b0;
        w_alu_a        = r_t;
        w_alu_b        = $signed(w_coef_rd);
        unique case (r_state)
            S_MUL: begin
                w_alu_ctrl.op = ALU_MUL;
                w_alu_a       = r_y;
                w_alu_b       = r_b1;
            end
            S_RND: begin
                w_alu_ctrl.op  = ALU_RND;
                // the last term, c0, uses y*b1 without doubling
                w_alu_ctrl.dbl = (r_idx != '0);
            end
            S_SUB: begin
                w_alu_ctrl.op = ALU_SUB;
                w_alu_b       = r_b2;
            end
            S_IDLE, S_START, S_DIV, S_ADD, S_FIN: begin
                w_alu_ctrl.op = ALU_ADD;
            end
        endcase
    end

    cse_alu u_alu (
        .i_clk  (i_clk),
        .i_ctrl (w_alu_ctrl),
        .i_a    (w_alu_a),
        .i_b    (w_alu_b),
        .o_res  (w_alu_res),
        .o_sat  (w_alu_sat)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_eval_acc) begin
                    n_state = (r_range_high == r_range_low) ? S_FIN : S_START;
                end
            end
            S_START: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_RND;
            end
            S_RND: begin
                n_state = S_SUB;
            end
            S_SUB: begin
                n_state = S_ADD;
            end
            S_ADD: begin
                n_state = (r_idx == '0) ? S_FIN : S_MUL;
            end
            S_FIN: begin
                if (w_fin_load) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_coef_count <= COEF_COUNT_RST;
            r_range_low  <= RANGE_LOW_RST;
            r_range_high <= RANGE_HIGH_RST;
        end else begin
            r_state <= n_state;
            if (w_fin_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_COEF_COUNT: r_coef_count <= i_cfg_wdata[CNT_W-1:0];
                    CFG_RANGE_LOW:  r_range_low  <= $signed(i_cfg_wdata);
                    CFG_RANGE_HIGH: r_range_high <= $signed(i_cfg_wdata);
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_eval_acc) begin
            r_x     <= i_x_value;
            r_b1    <= '0;
            r_b2    <= '0;
            r_idx   <= w_last_idx;
            r_sat   <= 1'b0;
            r_degen <= (r_range_high == r_range_low);
        end
        if (r_state == S_DIV && w_div_stat.done) begin
            r_y   <= w_y;
            r_sat <= r_sat | w_div_stat.sat;
        end
        if (r_state == S_RND || r_state == S_SUB) begin
            r_t   <= w_alu_res;
            r_sat <= r_sat | w_alu_sat;
        end
        if (r_state == S_ADD) begin
            r_b2  <= r_b1;
            r_b1  <= w_alu_res;
            r_sat <= r_sat | w_alu_sat;
            if (r_idx != '0) begin
                r_idx <= r_idx - 1'b1;
            end
        end
        if (w_fin_load) begin
            r_out_value <= r_degen ? '0 : r_b1;
            if (r_degen) begin
                r_out_status <= STATUS_DEGEN;
            end else if (r_sat) begin
                r_out_status <= STATUS_SAT;
            end else begin
                r_out_status <= STATUS_OK;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/cse_checker.sv
// ----------------------------------------------------------------------------
// cse_checker
// Port-level checks of the series evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic                                  o_stall,
    input  logic                                  i_operation,
    input  logic                                  o_valid,
    input  logic                                  i_stall,
    input  logic signed [cse_pkg::DATA_WIDTH-1:0] o_series_value,
    input  logic [1:0]                            o_status
);

    import cse_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_series_value) && $stable(o_status))
        else $error("result changed while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // an evaluation occupies the block
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_operation == OP_EVAL |=> o_stall)
        else $error("evaluation accepted without going busy");

    // a coefficient write leaves the block free
    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_operation == OP_WRITE |=> !o_stall)
        else $error("coefficient write made the block busy");

endmodule

bind chebyshev_series_eval_core cse_checker u_cse_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .i_operation    (i_operation),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_series_value (o_series_value),
    .o_status       (o_status)
);

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Chebyshev series evaluator. A driver feeds
// coefficient writes and evaluations from a queue of pending operations. A
// monitor compares every result with a Clenshaw predictor kept in the bench.
// The run steps through register settings and idle/stall patterns.
// ----------------------------------------------------------------------------

module tb_top;

    import cse_pkg::*;

    localparam int       WATCHDOG_LIMIT = 20000;
    localparam int       PRESSURE_HOLD  = 400;
    localparam t_cfg_idx CFG_UNUSED     = 2'd3;
    localparam longint   VMAX_L         = 64'sd2147483647;
    localparam longint   VMIN_L         = -64'sd2147483648;

    typedef struct {
        logic  op;
        logic  [CIDX_W-1:0] idx;
        t_data coef;
        t_data x;
    } op_item_t;

    typedef struct {
        t_data   value;
        t_status status;
    } sum_t;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DATA_WIDTH-1:0] i_cfg_wdata = '0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    logic                 i_operation = OP_WRITE;
    logic [CIDX_W-1:0]    i_coef_index = '0;
    t_data                i_coef_value = '0;
    t_data                i_x_value    = '0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    t_data                o_series_value;
    logic [1:0]           o_status;

    chebyshev_series_eval_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_coef_index   (i_coef_index),
        .i_coef_value   (i_coef_value),
        .i_x_value      (i_x_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_series_value (o_series_value),
        .o_status       (o_status)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // bench copy of the block state
    t_data             coef_mirror [COEF_DEPTH];
    logic [CNT_W-1:0]  cnt_reg  = COEF_COUNT_RST;
    t_data             low_reg  = RANGE_LOW_RST;
    t_data             high_reg = RANGE_HIGH_RST;
    bit                sat_hit;

    op_item_t pending_ops [$];
    sum_t     pending_sums [$];
    op_item_t cur_op;
    int       ops_left = 0;
    int       fail_cnt = 0;
    int       quiet_cycles = 0;
    int       send_pct = 0;
    int       recv_pct = 0;
    bit       hold_go = 1'b0;
    int       hold_left = 0;
    bit [COEF_DEPTH-1:0] slot_loaded = '0;

    // ------------------------------------------------------------------------
    // fixed point helpers, all values kept within the 32-bit signed range
    // ------------------------------------------------------------------------
    function automatic longint clamp_data(longint v);
        if (v > VMAX_L) begin
            sat_hit = 1'b1;
            return VMAX_L;
        end
        if (v < VMIN_L) begin
            sat_hit = 1'b1;
            return VMIN_L;
        end
        return v;
    endfunction

    function automatic longint from_mag(longint unsigned mag, bit neg);
        longint unsigned lim;
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        if (mag > lim) begin
            sat_hit = 1'b1;
            return neg ? VMIN_L : VMAX_L;
        end
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    // product rounded half away from zero
    function automatic longint mul_q(longint a, longint b);
        bit              neg;
        longint unsigned ua, ub, prod;
        neg  = (a < 0) != (b < 0);
        ua   = (a < 0) ? -a : a;
        ub   = (b < 0) ? -b : b;
        prod = (ua * ub + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return from_mag(prod, neg);
    endfunction

    function automatic longint div_q(longint n, longint d);
        bit              neg;
        longint unsigned un, ud, ip, rem, frac;
        neg  = (n < 0) != (d < 0);
        un   = (n < 0) ? -n : n;
        ud   = (d < 0) ? -d : d;
        ip   = un / ud;
        rem  = un % ud;
        frac = ((rem << (FRAC_BITS + 1)) + ud) / (ud * 2);
        if (ip > (64'd2147483647 >> FRAC_BITS)) begin
            sat_hit = 1'b1;
            return neg ? VMIN_L : VMAX_L;
        end
        return from_mag((ip << FRAC_BITS) + frac, neg);
    endfunction

    function automatic sum_t eval_series(t_data x_in);
        longint x, d, y, b1, b2, t, f;
        int     n, j;
        sum_t   r;
        sat_hit = 1'b0;
        x = x_in;
        d = longint'(high_reg) - longint'(low_reg);
        if (d == 0) begin
            r.value  = '0;
            r.status = STATUS_DEGEN;
            return r;
        end
        y = div_q(2 * x - longint'(low_reg) - longint'(high_reg), d);
        n = cnt_reg;
        if (n < 1) n = 1;
        if (n > COEF_DEPTH) n = COEF_DEPTH;
        b1 = 0;
        b2 = 0;
        for (j = n - 1; j >= 1; j--) begin
            t  = mul_q(y, b1);
            t  = clamp_data(t + t);
            t  = clamp_data(clamp_data(t - b2) + longint'(coef_mirror[j]));
            b2 = b1;
            b1 = t;
        end
        f = clamp_data(clamp_data(mul_q(y, b1) - b2) + longint'(coef_mirror[0]));
        r.value  = t_data'(f);
        r.status = sat_hit ? STATUS_SAT : STATUS_OK;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_data rand_coef();
        if ($urandom_range(9) < 7) return t_data'(int'($urandom_range(262143)) - 131072);
        return t_data'($urandom);
    endfunction

    // x inside the configured interval
    function automatic t_data pick_x();
        longint          a, b, s;
        longint unsigned uspan, r;
        a = low_reg;
        b = high_reg;
        if (a > b) begin
            s = a;
            a = b;
            b = s;
        end
        uspan = b - a;
        r = {$urandom, $urandom};
        return t_data'(a + longint'(r % (uspan + 1)));
    endfunction

    task automatic push_op(logic op, int idx, t_data coef, t_data x);
        op_item_t it;
        it.op   = op;
        it.idx  = idx[CIDX_W-1:0];
        it.coef = coef;
        it.x    = x;
        if (op == OP_WRITE) slot_loaded[idx] = 1'b1;
        ops_left++;
        pending_ops.push_back(it);
    endtask

    task automatic write_reg(t_cfg_idx idx, t_data data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_COEF_COUNT: cnt_reg  = data[CNT_W-1:0];
            CFG_RANGE_LOW:  low_reg  = data;
            CFG_RANGE_HIGH: high_reg = data;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (ops_left != 0 || pending_sums.size() != 0) @(posedge i_clk);
        // let trailing coefficient writes settle
        repeat (8) @(posedge i_clk);
    endtask

    task automatic queue_phase(int n_items);
        int k, eff, sel;
        eff = (cnt_reg == 0) ? 1 : ((cnt_reg > COEF_DEPTH) ? COEF_DEPTH : cnt_reg);
        // every slot in use is loaded before the first evaluation
        for (k = 0; k < eff; k++) begin
            if (!slot_loaded[k]) push_op(OP_WRITE, k, rand_coef(), t_data'($urandom));
        end
        for (k = 0; k < n_items; k++) begin
            sel = $urandom_range(99);
            push_op((sel < 35) ? OP_WRITE : OP_EVAL, $urandom_range(COEF_DEPTH - 1),
                    rand_coef(), ($urandom_range(3) == 0) ? t_data'($urandom) : pick_x());
        end
    endtask

    // ------------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                if (cur_op.op == OP_EVAL) begin
                    pending_sums.push_back(eval_series(cur_op.x));
                end else begin
                    coef_mirror[cur_op.idx] = cur_op.coef;
                end
                ops_left--;
            end
            if (!i_valid || !o_stall) begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= send_pct) begin
                    cur_op = pending_ops.pop_front();
                    i_valid      <= 1'b1;
                    i_operation  <= cur_op.op;
                    i_coef_index <= cur_op.idx;
                    i_coef_value <= cur_op.coef;
                    i_x_value    <= cur_op.x;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall, with one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_left = PRESSURE_HOLD;
            hold_go   = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_pct);
        end
    end

    // ------------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        sum_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_sums.size() == 0) begin
                $error("result transaction with no evaluation outstanding");
                fail_cnt++;
            end else begin
                want = pending_sums.pop_front();
                if (o_series_value !== want.value) begin
                    $error("series_value: expected %0d, actual %0d", want.value, o_series_value);
                    fail_cnt++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin : sequencer
        int    p, cnt, n_items;
        t_data lo, hi;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: reset settings, single coefficient, x at the extremes
        push_op(OP_WRITE, 0, 32'sd65536, '0);
        push_op(OP_EVAL, 0, '0, 32'sd0);
        push_op(OP_EVAL, 0, '0, VMAX);
        push_op(OP_EVAL, 0, '0, VMIN);
        push_op(OP_WRITE, 0, VMIN, '0);
        push_op(OP_EVAL, 0, '0, 32'sd65536);
        push_op(OP_WRITE, 0, VMAX, '0);
        push_op(OP_EVAL, 0, '0, -32'sd65536);
        drain();

        // three coefficients at full scale, saturating recurrence
        write_reg(CFG_COEF_COUNT, 32'd3);
        push_op(OP_WRITE, 1, VMAX, '0);
        push_op(OP_WRITE, 2, VMIN, '0);
        push_op(OP_EVAL, 0, '0, 32'sd65536);
        push_op(OP_EVAL, 0, '0, -32'sd32768);
        push_op(OP_EVAL, 0, '0, 32'sd0);
        push_op(OP_EVAL, 0, '0, 32'sd1);
        push_op(OP_WRITE, 1, -32'sd65536, '0);
        push_op(OP_WRITE, 2, 32'sd32768, '0);
        push_op(OP_EVAL, 0, '0, 32'sd32768);
        push_op(OP_EVAL, 0, '0, -32'sd1);
        drain();

        // degenerate range
        write_reg(CFG_RANGE_LOW, 32'sd12345);
        write_reg(CFG_RANGE_HIGH, 32'sd12345);
        push_op(OP_EVAL, 0, '0, 32'sd0);
        push_op(OP_EVAL, 0, '0, VMIN);
        drain();

        // reversed range, plus a write to the unused register index
        write_reg(CFG_RANGE_LOW, 32'sd65536);
        write_reg(CFG_RANGE_HIGH, -32'sd65536);
        write_reg(CFG_UNUSED, t_data'($urandom));
        push_op(OP_EVAL, 0, '0, 32'sd16384);
        push_op(OP_EVAL, 0, '0, VMAX);
        drain();

        // widest interval
        write_reg(CFG_RANGE_LOW, VMIN);
        write_reg(CFG_RANGE_HIGH, VMAX);
        push_op(OP_EVAL, 0, '0, VMIN);
        push_op(OP_EVAL, 0, '0, VMAX);
        push_op(OP_EVAL, 0, '0, 32'sd0);
        drain();

        // random phases; the last one runs the receiver hold-off
        for (p = 0; p < 13; p++) begin
            case (p)
                3:       cnt = 0;
                6:       cnt = 63;
                9:       cnt = 32;
                11:      cnt = 40;
                12:      cnt = 4;
                default: cnt = $urandom_range(6, 1);
            endcase
            case (p % 4)
                0: begin
                    lo = RANGE_LOW_RST;
                    hi = RANGE_HIGH_RST;
                end
                1: begin
                    lo = t_data'(int'($urandom_range(1048575)) - 524288);
                    hi = t_data'(int'($urandom_range(1048575)) - 524288);
                end
                2: begin
                    if (p == 10) begin
                        lo = t_data'($urandom);
                        hi = lo;
                    end else begin
                        lo = VMIN;
                        hi = VMAX;
                    end
                end
                default: begin
                    lo = t_data'($urandom);
                    hi = t_data'($urandom);
                end
            endcase
            if (p == 12) begin
                lo = RANGE_LOW_RST;
                hi = RANGE_HIGH_RST;
            end
            write_reg(CFG_COEF_COUNT, t_data'(cnt));
            write_reg(CFG_RANGE_LOW, lo);
            write_reg(CFG_RANGE_HIGH, hi);
            write_reg(CFG_UNUSED, t_data'($urandom));

            case ((p == 12) ? 0 : (p % 4))
                0: begin
                    send_pct = 0;
                    recv_pct = 0;
                end
                1: begin
                    send_pct = 88;
                    recv_pct = 0;
                end
                2: begin
                    send_pct = 0;
                    recv_pct = 88;
                end
                default: begin
                    send_pct = 8;
                    recv_pct = 8;
                end
            endcase
            n_items = (cnt > 6) ? 40 : 90;
            if (p == 12) begin
                hold_go  = 1'b1;
                n_items  = 100;
            end
            queue_phase(n_items);
            drain();
        end

        repeat (200) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/cse_pkg.sv
rtl/core/cse_ram.sv
rtl/core/cse_div.sv
rtl/core/cse_alu.sv
rtl/core/chebyshev_series_eval_core.sv
rtl/core/cse_checker.sv
dv/tb_top.sv
